FILE: rtl/core/tld_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes of the tty line discipline.
// Depends on nothing; the other RTL files but tld_ram refer to it by scoped names, and the testbench imports it.
package tld_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_REQ   = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_TILDE     = 8'd126;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  echo_char;
        logic [15:0] store_offset;
        logic [15:0] byte_count;
        logic        last;
    } result_t;

    // Up to two results produced in one cycle, first in order first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } line_res_t;

    function automatic logic is_printable(input logic [7:0] ch);
        is_printable = (ch >= CH_SPACE) && (ch <= CH_TILDE);
    endfunction

endpackage

FILE: rtl/core/tty_line_discipline.sv
`timescale 1ns / 1ps
// Top level of the keyboard line discipline: key FIFO control, read sequencing, ports.
// Depends on tld_pkg, tld_ram, tld_line and tld_resq.

// Keys, read requests and drain commands arrive as transfers on the s_axis side, with
// the command in tuser. A key transfer writes its byte into a 256-entry ring FIFO held
// in a synchronous RAM, or is dropped silently when the FIFO is full; it gives no
// result. A read request queues one acknowledge that carries the requested count. A
// drain of a non-empty FIFO reads the RAM in ST_IDLE; in ST_POP it sees the registered
// byte and queues none, one or two results (a store or erase echo, possibly followed
// by a line completion), and no new item is taken in ST_POP. So keys and requests are
// taken at one item per cycle while the result queue has room. Results leave through a
// four-entry queue on the m_axis side, one transfer per cycle while m_axis_tready is
// high, with tlast marking the final result of an item; new items are taken while
// earlier results wait there, as long as two slots are free.
module tty_line_discipline (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit first: key_byte[7:0], read_count[23:8].
    input  logic [23:0] s_axis_tdata,
    // tuser: mode[1:0].
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit first: echo_char[7:0], store_offset[23:8], byte_count[39:24].
    output logic [39:0] m_axis_tdata,
    // tuser: kind[1:0].
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic [tld_pkg::PTR_W-1:0]   wp_reg;
    logic [tld_pkg::PTR_W-1:0]   wp_next;
    logic [tld_pkg::PTR_W-1:0]   rp_reg;
    logic [tld_pkg::PTR_W-1:0]   rp_next;
    logic [tld_pkg::FILL_W-1:0]  fill_reg;
    logic [tld_pkg::FILL_W-1:0]  fill_next;

    logic                        accept;
    logic [1:0]                  mode;
    logic [7:0]                  key_byte;
    logic [15:0]                 read_count;
    logic                        fifo_full;
    logic                        fifo_empty;
    logic                        do_push;
    logic                        do_read;
    logic [7:0]                  ram_rdata;
    logic                        q_room;
    logic                        q_valid;
    tld_pkg::result_t            q_head;
    tld_pkg::line_res_t          line_res;

    assign mode       = s_axis_tuser;
    assign key_byte   = s_axis_tdata[7:0];
    assign read_count = s_axis_tdata[23:8];

    // Items are taken only while no drain is in flight and the result queue can
    // absorb a worst-case burst.
    assign s_axis_tready = (state_reg == ST_IDLE) && q_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign fifo_full  = (fill_reg == tld_pkg::FILL_W'(tld_pkg::FIFO_DEPTH));
    assign fifo_empty = (fill_reg == '0);
    assign do_push    = accept && (mode == tld_pkg::MODE_KEY) && !fifo_full;
    assign do_read    = accept && (mode == tld_pkg::MODE_DRAIN) && !fifo_empty;

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        fill_next  = fill_reg;
        state_next = state_reg;

        if (do_push)
        begin
            wp_next   = (wp_reg == tld_pkg::PTR_W'(tld_pkg::FIFO_DEPTH - 1))
                        ? '0 : wp_reg + tld_pkg::PTR_W'(1);
            fill_next = fill_reg + tld_pkg::FILL_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (do_read)
                begin
                    rp_next    = (rp_reg == tld_pkg::PTR_W'(tld_pkg::FIFO_DEPTH - 1))
                                 ? '0 : rp_reg + tld_pkg::PTR_W'(1);
                    fill_next  = fill_reg - tld_pkg::FILL_W'(1);
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                // The popped byte is on the RAM output now; results are queued.
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            fill_reg  <= fill_next;
        end
    end

    // A write and a read never hit the same entry in one cycle: a read only
    // happens when the entry was filled in an earlier cycle.
    tld_ram #(
        .DATA_W (8),
        .DEPTH  (tld_pkg::FIFO_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wp_reg),
        .wdata (key_byte),
        .re    (do_read),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    tld_line u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .arm       (accept && (mode == tld_pkg::MODE_REQ)),
        .arm_count (read_count),
        .pop_valid (state_reg == ST_POP),
        .pop_byte  (ram_rdata),
        .res       (line_res)
    );

    tld_resq u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (line_res),
        .pop   (m_axis_tready),
        .room  (q_room),
        .valid (q_valid),
        .head  (q_head)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {q_head.byte_count, q_head.store_offset, q_head.echo_char};
    assign m_axis_tuser  = q_head.kind;
    assign m_axis_tlast  = q_head.last;

    // The fill count never exceeds the FIFO depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= tld_pkg::FILL_W'(tld_pkg::FIFO_DEPTH))
        else $error("key FIFO fill count above depth");

    // An empty FIFO has matching pointers.
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (wp_reg == rp_reg))
        else $error("key FIFO empty with unequal pointers");

    // A drain's ST_POP state blocks new items and is followed by ST_IDLE.
    a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (!s_axis_tready ##1 (state_reg == ST_IDLE)))
        else $error("drain sequencing broken");

    // Every drain that reads the RAM was accepted with a non-empty FIFO.
    a_pop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_POP) |-> $past(do_read))
        else $error("RAM read without a drain");

endmodule

FILE: rtl/core/tld_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with a registered read port.
// Standalone; used as the key byte store.
module tld_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/tld_line.sv
`timescale 1ns / 1ps
// Canonical read state: remaining and moved counts, and result generation.
// Depends on tld_pkg.
module tld_line (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                arm,
    input  logic [15:0]         arm_count,
    input  logic                pop_valid,
    input  logic [7:0]          pop_byte,
    output tld_pkg::line_res_t  res
);

    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic [15:0] bytes_moved_reg;
    logic [15:0] bytes_moved_next;

    always_comb
    begin
        tld_pkg::result_t r0;
        tld_pkg::result_t r1;
        logic [1:0]       n;
        logic [15:0]      l;
        logic [15:0]      m;

        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        l  = bytes_left_reg;
        m  = bytes_moved_reg;

        if (arm)
        begin
            r0.kind       = tld_pkg::KIND_ACK;
            r0.byte_count = arm_count;
            r0.last       = 1'b1;
            n             = 2'd1;
            l             = arm_count;
            m             = 16'd0;
        end
        else if (pop_valid && (bytes_left_reg != 16'd0))
        begin
            if (tld_pkg::is_printable(pop_byte))
            begin
                r0.kind         = tld_pkg::KIND_STORE;
                r0.echo_char    = pop_byte;
                r0.store_offset = m;
                n               = 2'd1;
                m               = m + 16'd1;
                l               = l - 16'd1;
            end
            else if ((pop_byte == tld_pkg::CH_BACKSPACE) && (m != 16'd0))
            begin
                r0.kind      = tld_pkg::KIND_ERASE;
                r0.echo_char = pop_byte;
                n            = 2'd1;
                m            = m - 16'd1;
                l            = l + 16'd1;
            end

            // Newline or a used-up count closes the read.
            if ((pop_byte == tld_pkg::CH_NEWLINE) || (l == 16'd0))
            begin
                if (n == 2'd0)
                begin
                    r0.kind       = tld_pkg::KIND_DONE;
                    r0.echo_char  = tld_pkg::CH_NEWLINE;
                    r0.byte_count = m;
                end
                else
                begin
                    r1.kind       = tld_pkg::KIND_DONE;
                    r1.echo_char  = tld_pkg::CH_NEWLINE;
                    r1.byte_count = m;
                end
                n = n + 2'd1;
                l = 16'd0;
            end

            if (n == 2'd1)
            begin
                r0.last = 1'b1;
            end
            else if (n == 2'd2)
            begin
                r1.last = 1'b1;
            end
        end

        res.count        = n;
        res.first        = r0;
        res.second       = r1;
        bytes_left_next  = l;
        bytes_moved_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= 16'd0;
            bytes_moved_reg <= 16'd0;
        end
        else
        begin
            bytes_left_reg  <= bytes_left_next;
            bytes_moved_reg <= bytes_moved_next;
        end
    end

endmodule

FILE: rtl/core/tld_resq.sv
`timescale 1ns / 1ps
// Small result queue that takes up to two results a cycle and hands out one when popped.
// Depends on tld_pkg.
module tld_resq (
    input  logic               clk,
    input  logic               rst_n,
    input  tld_pkg::line_res_t push,
    input  logic               pop,
    output logic               room,
    output logic               valid,
    output tld_pkg::result_t   head
);

    tld_pkg::result_t entries [tld_pkg::QDEPTH];

    logic [tld_pkg::QPTR_W-1:0] wp_reg;
    logic [tld_pkg::QPTR_W-1:0] wp_next;
    logic [tld_pkg::QPTR_W-1:0] rp_reg;
    logic [tld_pkg::QPTR_W-1:0] rp_next;
    logic [tld_pkg::QCNT_W-1:0] count_reg;
    logic [tld_pkg::QCNT_W-1:0] count_next;
    logic                       do_pop;

    assign valid  = (count_reg != '0);
    assign head   = entries[rp_reg];
    assign do_pop = pop && valid;
    // Room for the largest burst a single item can cause.
    assign room   = (count_reg <= tld_pkg::QCNT_W'(tld_pkg::QDEPTH - 2));

    always_comb
    begin
        wp_next    = wp_reg + tld_pkg::QPTR_W'(push.count);
        rp_next    = rp_reg + tld_pkg::QPTR_W'(do_pop);
        count_next = count_reg + tld_pkg::QCNT_W'(push.count)
                     - tld_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries[wp_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entries[wp_reg + tld_pkg::QPTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of tty_line_discipline. It drives key, read-request and drain
// transfers with random gaps, predicts each result, and checks results in order.
// Depends on tld_pkg and the RTL of the block.
module tb;
    import tld_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predicted state of the key FIFO and of the pending read.
    logic [7:0]       key_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] key_wr = '0;
    logic [PTR_W-1:0] key_rd = '0;
    int               key_fill = 0;
    logic [15:0]      read_left = '0;
    logic [15:0]      read_moved = '0;

    result_t     expected_results [$];

    int mismatches = 0;
    int items_sent = 0;
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;
    int rx_hold = 0;

    always #6 clk = ~clk;

    tty_line_discipline dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_count();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] ch,
                                            input logic [15:0] offset,
                                            input logic [15:0] count);
        result_t r;
        r.kind = kind;
        r.echo_char = ch;
        r.store_offset = offset;
        r.byte_count = count;
        r.last = 1'b0;
        return r;
    endfunction

    // Line discipline predictor: updates the FIFO and read state for one accepted
    // transfer and queues the results it gives, tlast on the final one.
    task automatic predict_item(input logic [1:0] mode, input logic [7:0] key,
                                input logic [15:0] count);
        result_t    res [2];
        int         n;
        logic [7:0] ch;
        n = 0;
        if (mode == MODE_KEY)
        begin
            if (key_fill < FIFO_DEPTH)
            begin
                key_mem[key_wr] = key;
                key_wr = (key_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : key_wr + PTR_W'(1);
                key_fill++;
            end
        end
        else if (mode == MODE_REQ)
        begin
            read_left = count;
            read_moved = '0;
            res[0] = make_result(KIND_ACK, 8'd0, 16'd0, count);
            n = 1;
        end
        else if (mode == MODE_DRAIN && key_fill != 0)
        begin
            ch = key_mem[key_rd];
            key_rd = (key_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : key_rd + PTR_W'(1);
            key_fill--;
            if (read_left != 16'd0)
            begin
                if (ch >= CH_SPACE && ch <= CH_TILDE)
                begin
                    res[n] = make_result(KIND_STORE, ch, read_moved, 16'd0);
                    n++;
                    read_moved = read_moved + 16'd1;
                    read_left = read_left - 16'd1;
                end
                else if (ch == CH_BACKSPACE && read_moved != 16'd0)
                begin
                    res[n] = make_result(KIND_ERASE, ch, 16'd0, 16'd0);
                    n++;
                    read_moved = read_moved - 16'd1;
                    read_left = read_left + 16'd1;
                end
                // A newline or a used-up count closes the read.
                if (ch == CH_NEWLINE || read_left == 16'd0)
                begin
                    res[n] = make_result(KIND_DONE, CH_NEWLINE, 16'd0, read_moved);
                    n++;
                    read_left = '0;
                end
            end
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(res[i]);
    endtask

    // Sends one item. Valid stays high after the transfer so that back-to-back items
    // need no second assignment in the same time step; it drops before a gap or in hold_until_drained.
    task automatic push_item(input logic [1:0] mode, input logic [7:0] key,
                             input logic [15:0] count);
        int gap;
        gap = tx_gaps ? idle_length() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {count, key};
        s_axis_tuser <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_item(mode, key, count);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    // The sender holds off until every predicted result has left the block.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Ignored mode, drain of an empty FIFO, a zero-count request and a discarded byte,
    // then one read that sees every kind of byte: a backspace with nothing stored, both
    // ends of the printable range, the non-printable bytes around it, the top byte,
    // two erasures, a spare backspace and the closing newline.
    task automatic test_special_bytes();
        logic [7:0] typed [11] = '{CH_BACKSPACE, CH_SPACE, CH_TILDE, 8'd31, 8'd127,
                                   8'hFF, 8'h00, CH_BACKSPACE, CH_BACKSPACE,
                                   CH_BACKSPACE, CH_NEWLINE};
        push_item(MODE_UNUSED, 8'hFF, 16'hFFFF);
        push_item(MODE_DRAIN, 8'h00, 16'h0000);
        push_item(MODE_REQ, 8'h00, 16'h0000);
        push_item(MODE_KEY, 8'h41, 16'h0000);
        push_item(MODE_DRAIN, 8'hFF, 16'hFFFF);
        push_item(MODE_REQ, 8'h00, 16'hFFFF);
        foreach (typed[i])
        begin
            push_item(MODE_KEY, typed[i], rand_count());
            push_item(MODE_DRAIN, rand_byte(), rand_count());
        end
        hold_until_drained();
    endtask

    // A read that runs out of count, with a store and the completion from one drain,
    // then a request that replaces a pending one and restarts the stored count.
    task automatic test_count_and_replace();
        push_item(MODE_REQ, 8'h00, 16'd2);
        push_item(MODE_KEY, 8'h78, 16'h0000);
        push_item(MODE_KEY, 8'h79, 16'h0000);
        push_item(MODE_KEY, 8'h7A, 16'h0000);
        repeat (3) push_item(MODE_DRAIN, 8'h00, 16'h0000);
        push_item(MODE_REQ, 8'h00, 16'd5);
        push_item(MODE_KEY, 8'h61, 16'h0000);
        push_item(MODE_DRAIN, 8'h00, 16'h0000);
        push_item(MODE_REQ, 8'h00, 16'd3);
        push_item(MODE_KEY, 8'h62, 16'h0000);
        push_item(MODE_DRAIN, 8'h00, 16'h0000);
        push_item(MODE_KEY, CH_NEWLINE, 16'h0000);
        push_item(MODE_DRAIN, 8'h00, 16'h0000);
        hold_until_drained();
    endtask

    // Keys at full rate past the FIFO size, so the last few are dropped, then one long
    // read drains it all and two more drains find it empty.
    task automatic test_fifo_full();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        repeat (FIFO_DEPTH + 4)
            push_item(MODE_KEY, rand_byte(), 16'h0000);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        push_item(MODE_REQ, 8'h00, 16'hFFFF);
        repeat (FIFO_DEPTH + 2)
            push_item(MODE_DRAIN, 8'h00, 16'h0000);
        push_item(MODE_KEY, CH_NEWLINE, 16'h0000);
        push_item(MODE_DRAIN, 8'h00, 16'h0000);
        hold_until_drained();
    endtask

    // Mostly well-formed reads: a request, a typed line with keys and drains mixed,
    // then the FIFO drained empty. The rest is random noise, unused mode included.
    task automatic test_random_lines();
        int         target;
        int         len;
        int         pick;
        logic [15:0] count;
        logic [7:0] ch;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    count = 16'($urandom_range(1, 24));
                else if (pick < 9)
                    count = rand_count();
                else
                    count = 16'd0;
                push_item(MODE_REQ, rand_byte(), count);
                len = $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        ch = 8'($urandom_range(CH_SPACE, CH_TILDE));
                    else if (pick < 85)
                        ch = CH_BACKSPACE;
                    else if (pick < 90)
                        ch = CH_NEWLINE;
                    else
                        ch = rand_byte();
                    push_item(MODE_KEY, ch, rand_count());
                    if ($urandom_range(0, 2) == 0)
                        push_item(MODE_DRAIN, rand_byte(), rand_count());
                end
                if ($urandom_range(0, 1) == 1)
                    push_item(MODE_KEY, CH_NEWLINE, rand_count());
                while (key_fill != 0)
                    push_item(MODE_DRAIN, rand_byte(), rand_count());
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    push_item(2'($urandom_range(0, 3)), rand_byte(), rand_count());
            end
            if ($urandom_range(0, 19) == 0)
                hold_until_drained();
        end
    endtask

    // Result side back-pressure: runs of stalls, switched off in some stretches.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stalls && $urandom_range(0, 99) < 25)
        begin
            rx_hold <= idle_length();
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Each result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        logic    bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d char %0d offset %0d count %0d %s %0b",
                             m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8],
                             m_axis_tdata[39:24], "last", m_axis_tlast);
            end
            else
            begin
                want = expected_results.pop_front();
                bad = (m_axis_tuser != want.kind) || (m_axis_tdata[7:0] != want.echo_char)
                      || (m_axis_tdata[23:8] != want.store_offset)
                      || (m_axis_tdata[39:24] != want.byte_count)
                      || (m_axis_tlast != want.last);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result differs: expected kind %0d char %0d offset %0d %s",
                                 want.kind, want.echo_char, want.store_offset, "");
                        $display("    count %0d last %0b, got kind %0d char %0d offset %0d",
                                 want.byte_count, want.last, m_axis_tuser,
                                 m_axis_tdata[7:0], m_axis_tdata[23:8]);
                        $display("    count %0d last %0b",
                                 m_axis_tdata[39:24], m_axis_tlast);
                    end
                end
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tty_line_discipline: mismatch");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_special_bytes();
        test_count_and_replace();
        test_fifo_full();
        test_random_lines();
        hold_until_drained();
        // A drain passes through ST_IDLE and ST_POP inside the block; leave room for any stray result.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tty_line_discipline: match");
        else
            $display("tty_line_discipline: mismatch");
        $finish;
    end

endmodule
